@@ src/sfp_pkg.sv @@
// Shared types and constants for the serial frame parser.
package sfp_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int IN_DATA_W = 40;
    localparam int OUT_FIELDS_W = 8 + LEN_W + IDX_W + 8 + 32;
    localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 4;

    typedef enum logic [2:0] {
        PH_SOF,
        PH_CMD,
        PH_LEN,
        PH_PAY,
        PH_CHK
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY,
        ST_OK,
        ST_CHK,
        ST_TIMEOUT,
        ST_LEN
    } status_t;

    typedef struct packed {
        logic             drain;
        status_t          status;
        logic [7:0]       command;
        logic [LEN_W-1:0] length;
        logic [31:0]      gap;
    } job_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

endpackage

@@ src/sfp_front.sv @@
// Front end: frame state machine, timeout check and result job generation.
module sfp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic [31:0]         arrival_time,
    input  logic                q_full,
    output logic                push,
    output sfp_pkg::job_t       job,
    output sfp_pkg::store_wr_t  store_wr,
    input  logic                drain_done
);

    sfp_pkg::phase_t                phase_reg, phase_next;
    logic [7:0]                     cmd_reg, cmd_next;
    logic [sfp_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [sfp_pkg::LEN_W-1:0]      count_reg, count_next;
    logic [sfp_pkg::LEN_W-1:0]      count_inc;
    logic [7:0]                     xor_reg, xor_next;
    logic [31:0]                    prev_reg;
    logic [31:0]                    limit_reg;
    logic                           pending_reg, pending_next;
    logic [31:0]                    gap;
    logic                           timed_out;
    logic                           take;
    sfp_pkg::phase_t                eff_phase;

    assign in_ready = !q_full && !(phase_reg == sfp_pkg::PH_PAY && pending_reg);
    assign take     = in_valid && in_ready;
    assign push     = take;
    assign gap      = arrival_time - prev_reg;
    assign timed_out = (limit_reg != 32'd0) && (phase_reg != sfp_pkg::PH_SOF)
                       && (gap > limit_reg);
    assign count_inc = count_reg + sfp_pkg::LEN_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        job.drain   = 1'b0;
        job.status  = timed_out ? sfp_pkg::ST_TIMEOUT : sfp_pkg::ST_BUSY;
        job.command = 8'd0;
        job.length  = '0;
        job.gap     = timed_out ? gap : 32'd0;
        store_wr.en   = 1'b0;
        store_wr.addr = count_reg[sfp_pkg::IDX_W-1:0];
        store_wr.data = rx_byte;
        eff_phase   = timed_out ? sfp_pkg::PH_SOF : phase_reg;
        case (eff_phase)
            sfp_pkg::PH_SOF:
            begin
                phase_next = sfp_pkg::PH_SOF;
                if (rx_byte == sfp_pkg::START_BYTE)
                begin
                    phase_next = sfp_pkg::PH_CMD;
                    count_next = '0;
                end
            end
            sfp_pkg::PH_CMD:
            begin
                cmd_next   = rx_byte;
                xor_next   = rx_byte;
                phase_next = sfp_pkg::PH_LEN;
            end
            sfp_pkg::PH_LEN:
            begin
                if ({1'b0, rx_byte} > 9'(sfp_pkg::MAX_PAYLOAD))
                begin
                    phase_next = sfp_pkg::PH_SOF;
                    job.status = sfp_pkg::ST_LEN;
                end
                else
                begin
                    len_next   = rx_byte[sfp_pkg::LEN_W-1:0];
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = (rx_byte == 8'd0) ? sfp_pkg::PH_CHK : sfp_pkg::PH_PAY;
                end
            end
            sfp_pkg::PH_PAY:
            begin
                store_wr.en = take;
                count_next  = count_inc;
                xor_next    = xor_reg ^ rx_byte;
                if (count_inc >= len_reg)
                begin
                    phase_next = sfp_pkg::PH_CHK;
                end
            end
            sfp_pkg::PH_CHK:
            begin
                phase_next = sfp_pkg::PH_SOF;
                if (rx_byte == xor_reg)
                begin
                    job.status  = sfp_pkg::ST_OK;
                    job.command = cmd_reg;
                    job.length  = len_reg;
                    job.drain   = (len_reg != '0);
                end
                else
                begin
                    job.status = sfp_pkg::ST_CHK;
                end
            end
            default:
            begin
                phase_next = sfp_pkg::PH_SOF;
            end
        endcase
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (take && job.drain)
        begin
            pending_next = 1'b1;
        end
        else if (drain_done)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sfp_pkg::PH_SOF;
            prev_reg    <= 32'd0;
            limit_reg   <= 32'd0;
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
            if (take)
            begin
                phase_reg <= phase_next;
                prev_reg  <= arrival_time;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

@@ src/sfp_queue.sv @@
// Job queue between the front end and the result sequencer.
module sfp_queue
#(
    parameter int DEPTH = sfp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfp_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output sfp_pkg::job_t  head_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfp_pkg::job_t     entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ src/sfp_back.sv @@
// Back end: payload store and result sequencer with output register.
module sfp_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sfp_pkg::store_wr_t                   store_wr,
    input  logic                                 head_valid,
    input  sfp_pkg::job_t                        head_job,
    output logic                                 pop,
    output logic                                 drain_done,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sfp_pkg::OUT_DATA_W-1:0]       out_data,
    output logic [sfp_pkg::OUT_USER_W-1:0]       out_user,
    output logic                                 out_last
);

    logic [7:0]                 store_reg [sfp_pkg::MAX_PAYLOAD];
    logic [7:0]                 rd_data_reg;
    logic [sfp_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                       load;
    logic                       final_beat;

    logic                       out_valid_reg, out_valid_next;
    sfp_pkg::status_t           out_status_reg;
    logic [7:0]                 out_cmd_reg;
    logic [sfp_pkg::LEN_W-1:0]  out_len_reg;
    logic                       out_pv_reg;
    logic [sfp_pkg::IDX_W-1:0]  out_idx_reg;
    logic [7:0]                 out_val_reg;
    logic [31:0]                out_gap_reg;
    logic                       out_last_reg;

    assign load       = head_valid && (!out_valid_reg || out_ready);
    assign final_beat = !head_job.drain
                        || ((sfp_pkg::LEN_W'(idx_reg) + sfp_pkg::LEN_W'(1)) == head_job.length);
    assign pop        = load && final_beat;
    assign drain_done = pop && head_job.drain;

    always_comb
    begin
        idx_next = idx_reg;
        if (load && head_job.drain)
        begin
            idx_next = final_beat ? '0 : idx_reg + sfp_pkg::IDX_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_reg[store_wr.addr] <= store_wr.data;
        end
        rd_data_reg <= store_reg[idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg <= head_job.status;
            out_cmd_reg    <= head_job.command;
            out_len_reg    <= head_job.length;
            out_gap_reg    <= head_job.gap;
            out_pv_reg     <= head_job.drain;
            out_idx_reg    <= head_job.drain ? idx_reg : '0;
            out_val_reg    <= head_job.drain ? rd_data_reg : 8'd0;
            out_last_reg   <= final_beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = sfp_pkg::OUT_DATA_W'({out_gap_reg, out_val_reg, out_idx_reg,
                                             out_len_reg, out_cmd_reg});
    assign out_user  = {out_pv_reg, out_status_reg};
    assign out_last  = out_last_reg;

endmodule

@@ src/serial_frame_parser.sv @@
// Top level of the serial frame parser.
//
// Takes one received byte per cycle with its timestamp unless stalled, and gives one result
// beat per byte, except the checksum byte of a good frame with N > 0 payload bytes, which
// gives N beats (the last one marked with tlast). A byte's job passes through the job queue
// into the output register. The front end stalls when the job queue is full, and it holds a
// payload byte while the payload of the previous good frame is still being read out of the
// payload store, one byte per cycle unless stalled. No clearing pass follows reset.
module serial_frame_parser
#(
    parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [31:0]                       cfg_wdata,     // timeout_limit
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sfp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // rx_byte, arrival_time
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // command, payload length, payload_index, payload_value, gap_ms, zero fill
    output logic [sfp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [sfp_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // status, payload_valid
    output logic                              m_axis_tlast
);

    logic                q_full;
    logic                push;
    logic                pop;
    logic                head_valid;
    logic                drain_done;
    sfp_pkg::job_t       push_job;
    sfp_pkg::job_t       head_job;
    sfp_pkg::store_wr_t  store_wr;

    sfp_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .rx_byte      (s_axis_tdata[7:0]),
        .arrival_time (s_axis_tdata[39:8]),
        .q_full       (q_full),
        .push         (push),
        .job          (push_job),
        .store_wr     (store_wr),
        .drain_done   (drain_done)
    );

    sfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    sfp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .store_wr   (store_wr),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .drain_done (drain_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_user   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

@@ src/sfp_checker.sv @@
// Port-level checks for the serial frame parser and their bind.
module sfp_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [sfp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic [sfp_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    input  logic                            m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tlast)
        else $error("status result without tlast");

    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == sfp_pkg::ST_OK)
        else $error("payload beat without frame ok status");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] != sfp_pkg::ST_TIMEOUT
        |-> m_axis_tdata[56:25] == 32'd0)
        else $error("nonzero gap outside a timeout");

endmodule

bind serial_frame_parser sfp_checker u_sfp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
